[sv/cgpp_pkg.sv]
// cgpp_pkg: shared types and preset codes for the color grading block
// depends on nothing; imported by cgpp_grade_pipe, color_grade_pixel_presets and tb_top
package cgpp_pkg;

    // preset codes held in the grading mode register
    localparam logic [2:0] MODE_IDENTITY  = 3'd0;
    localparam logic [2:0] MODE_WARM      = 3'd1;
    localparam logic [2:0] MODE_COOL      = 3'd2;
    localparam logic [2:0] MODE_CINEMATIC = 3'd3;
    localparam logic [2:0] MODE_VINTAGE   = 3'd4;
    localparam logic [2:0] MODE_NOIR      = 3'd5;
    // spare codes, graded as identity
    localparam logic [2:0] MODE_SPARE6    = 3'd6;
    localparam logic [2:0] MODE_SPARE7    = 3'd7;

    // input pixel
    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_in_t;

    // graded pixel
    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } pixel_out_t;

    // control that travels with each pixel down the pipeline
    typedef struct packed {
        logic       valid;
        logic [2:0] mode;
    } stage_ctrl_t;

endpackage

[sv/cgpp_grade_pipe.sv]
// cgpp_grade_pipe: five register stage fixed point grading datapath
// depends on cgpp_pkg for pixel types, control struct and preset codes
module cgpp_grade_pipe
    import cgpp_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 14
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  stage_ctrl_t ctrl_in,
    input  pixel_in_t   px_in,
    output stage_ctrl_t ctrl_out,
    output pixel_out_t  px_out
);

    localparam int F = COEF_FRAC_BITS;
    localparam int W = F + 10;

    // coefficients, rounded half up to F fraction bits
    localparam logic [W-1:0] K299 = W'(((299 << F) + 500) / 1000);
    localparam logic [W-1:0] K587 = W'(((587 << F) + 500) / 1000);
    localparam logic [W-1:0] K114 = W'(((114 << F) + 500) / 1000);
    localparam logic [W-1:0] K115 = W'(((115 << F) + 50) / 100);
    localparam logic [W-1:0] K105 = W'(((105 << F) + 50) / 100);
    localparam logic [W-1:0] K85  = W'(((85 << F) + 50) / 100);
    localparam logic [W-1:0] K120 = W'(((120 << F) + 50) / 100);
    localparam logic [W-1:0] K110 = W'(((110 << F) + 50) / 100);
    localparam logic [W-1:0] K10  = W'(((10 << F) + 50) / 100);
    localparam logic [W-1:0] K95  = W'(((95 << F) + 50) / 100);
    localparam logic [W-1:0] K15  = W'(((15 << F) + 50) / 100);
    localparam logic [W-1:0] K80  = W'(((80 << F) + 50) / 100);
    localparam logic [W-1:0] K150 = W'(((150 << F) + 50) / 100);

    // offsets on the 0..255 scale
    localparam logic [W-1:0] OFS5   = W'(255 * (((5 << F) + 50) / 100));
    localparam logic [W-1:0] OFS15  = W'(255 * (((15 << F) + 50) / 100));
    localparam logic [W-1:0] OFS30  = W'(255 * (((30 << F) + 50) / 100));
    localparam logic [W-1:0] OFS50  = W'(255 * (((50 << F) + 50) / 100));
    localparam logic [W-1:0] ONE_FX = W'(255 << F);

    // fixed times fixed, truncated
    function automatic logic [W-1:0] fx_mul(input logic [W-1:0] a, input logic [W-1:0] k);
        logic [2*W-1:0] p;
        p = a * k;
        return W'(p >> F);
    endfunction

    // clamp to full scale
    function automatic logic [W-1:0] sat_one(input logic [W-1:0] v);
        return (v > ONE_FX) ? ONE_FX : v;
    endfunction

    // integer part clamped to a byte
    function automatic logic [7:0] to_byte(input logic [W-1:0] v);
        logic [W-F-1:0] i;
        i = v[W-1:F];
        return (i > (W-F)'(255)) ? 8'd255 : i[7:0];
    endfunction

    // stage 1: captured pixel
    stage_ctrl_t s1_ctrl_reg;
    pixel_in_t   s1_px_reg;

    // stage 2: luma, channel products, simple preset result
    stage_ctrl_t    s2_ctrl_reg, s2_ctrl_next;
    logic [W-1:0]   s2_lum_reg, s2_lum_next;
    logic [W-1:0]   s2_rdiff_reg, s2_rdiff_next;
    logic [W-1:0]   s2_gk95_reg, s2_gk95_next;
    logic [W-1:0]   s2_bdiff_reg, s2_bdiff_next;
    pixel_out_t     s2_early_reg, s2_early_next;

    // stage 3: adjusted luma, vintage tones, noir deviation
    stage_ctrl_t    s3_ctrl_reg;
    logic [W-1:0]   s3_lumc_reg, s3_lumc_next;
    logic [W-1:0]   s3_vr_reg, s3_vr_next;
    logic [W-1:0]   s3_vg_reg, s3_vg_next;
    logic [W-1:0]   s3_vb_reg, s3_vb_next;
    logic           s3_nup_reg, s3_nup_next;
    logic [W-1:0]   s3_ndiff_reg, s3_ndiff_next;
    logic [W-1:0]   s3_rdiff_reg, s3_gk95_reg, s3_bdiff_reg;
    pixel_out_t     s3_early_reg;

    // stage 4: luma tint terms, faded vintage, scaled noir deviation
    stage_ctrl_t    s4_ctrl_reg;
    logic [W-1:0]   s4_t10_reg, s4_t10_next;
    logic [W-1:0]   s4_t15_reg, s4_t15_next;
    logic [W-1:0]   s4_vr_reg, s4_vr_next;
    logic [W-1:0]   s4_vg_reg, s4_vg_next;
    logic [W-1:0]   s4_vb_reg, s4_vb_next;
    logic           s4_nup_reg;
    logic [W-1:0]   s4_nd_reg, s4_nd_next;
    logic [W-1:0]   s4_rdiff_reg, s4_gk95_reg, s4_bdiff_reg;
    pixel_out_t     s4_early_reg;

    // output stage
    stage_ctrl_t    out_ctrl_reg;
    pixel_out_t     out_px_reg, out_px_next;

    logic [W-1:0]   r_w, g_w, b_w;
    logic [W-1:0]   lum80;
    logic [W-1:0]   noir_v;

    assign r_w = W'(s1_px_reg.red_in);
    assign g_w = W'(s1_px_reg.green_in);
    assign b_w = W'(s1_px_reg.blue_in);

    // stage 1 logic: luma, per-channel constant products, warm and cool results
    always_comb
    begin
        s2_ctrl_next  = s1_ctrl_reg;
        s2_lum_next   = r_w * K299 + g_w * K587 + b_w * K114;
        s2_rdiff_next = r_w * K110 - r_w * K10;
        s2_gk95_next  = g_w * K95;
        s2_bdiff_next = b_w * K105 - b_w * K15;
        case (s1_ctrl_reg.mode)
            MODE_WARM:
            begin
                s2_early_next.red_out   = to_byte(sat_one(r_w * K115 + OFS5));
                s2_early_next.green_out = to_byte(sat_one(g_w * K105));
                s2_early_next.blue_out  = to_byte(b_w * K85);
            end
            MODE_COOL:
            begin
                s2_early_next.red_out   = to_byte(r_w * K85);
                s2_early_next.green_out = to_byte(sat_one(g_w * K105));
                s2_early_next.blue_out  = to_byte(sat_one(b_w * K120 + OFS5));
            end
            default:
            begin
                s2_early_next.red_out   = s1_px_reg.red_in;
                s2_early_next.green_out = s1_px_reg.green_in;
                s2_early_next.blue_out  = s1_px_reg.blue_in;
            end
        endcase
    end

    // stage 2 logic: dark lift, vintage tones, noir deviation magnitude
    always_comb
    begin
        lum80         = fx_mul(s2_lum_reg, K80);
        s3_lumc_next  = (s2_lum_reg < OFS30) ? lum80 + OFS5 : s2_lum_reg;
        s3_vr_next    = sat_one(fx_mul(s2_lum_reg, K120));
        s3_vg_next    = sat_one(s2_lum_reg);
        s3_vb_next    = sat_one(lum80);
        s3_nup_next   = (s2_lum_reg >= OFS50);
        s3_ndiff_next = s3_nup_next ? s2_lum_reg - OFS50 : OFS50 - s2_lum_reg;
    end

    // stage 3 logic: tint terms, fade, contrast scale
    always_comb
    begin
        s4_t10_next = fx_mul(s3_lumc_reg, K10);
        s4_t15_next = fx_mul(s3_lumc_reg, K15);
        s4_vr_next  = fx_mul(s3_vr_reg, K85) + OFS15;
        s4_vg_next  = fx_mul(s3_vg_reg, K85) + OFS15;
        s4_vb_next  = fx_mul(s3_vb_reg, K85) + OFS15;
        s4_nd_next  = fx_mul(s3_ndiff_reg, K150);
    end

    // stage 4 logic: finish each preset and pick by mode
    always_comb
    begin
        if (s4_nup_reg)
            noir_v = sat_one(OFS50 + s4_nd_reg);
        else if (s4_nd_reg >= OFS50)
            noir_v = '0;
        else
            noir_v = OFS50 - s4_nd_reg;
        case (s4_ctrl_reg.mode)
            MODE_CINEMATIC:
            begin
                out_px_next.red_out   = to_byte(sat_one(s4_rdiff_reg + s4_t10_reg));
                out_px_next.green_out = to_byte(sat_one(s4_gk95_reg));
                out_px_next.blue_out  = to_byte(sat_one(s4_bdiff_reg + s4_t15_reg));
            end
            MODE_VINTAGE:
            begin
                out_px_next.red_out   = to_byte(s4_vr_reg);
                out_px_next.green_out = to_byte(s4_vg_reg);
                out_px_next.blue_out  = to_byte(s4_vb_reg);
            end
            MODE_NOIR:
            begin
                out_px_next.red_out   = to_byte(noir_v);
                out_px_next.green_out = to_byte(noir_v);
                out_px_next.blue_out  = to_byte(noir_v);
            end
            default:
            begin
                out_px_next = s4_early_reg;
            end
        endcase
    end

    // valid bits and modes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg  <= '0;
            s2_ctrl_reg  <= '0;
            s3_ctrl_reg  <= '0;
            s4_ctrl_reg  <= '0;
            out_ctrl_reg <= '0;
        end
        else
        begin
            s1_ctrl_reg  <= ctrl_in;
            s2_ctrl_reg  <= s2_ctrl_next;
            s3_ctrl_reg  <= s2_ctrl_reg;
            s4_ctrl_reg  <= s3_ctrl_reg;
            out_ctrl_reg <= s4_ctrl_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        s1_px_reg    <= px_in;

        s2_lum_reg   <= s2_lum_next;
        s2_rdiff_reg <= s2_rdiff_next;
        s2_gk95_reg  <= s2_gk95_next;
        s2_bdiff_reg <= s2_bdiff_next;
        s2_early_reg <= s2_early_next;

        s3_lumc_reg  <= s3_lumc_next;
        s3_vr_reg    <= s3_vr_next;
        s3_vg_reg    <= s3_vg_next;
        s3_vb_reg    <= s3_vb_next;
        s3_nup_reg   <= s3_nup_next;
        s3_ndiff_reg <= s3_ndiff_next;
        s3_rdiff_reg <= s2_rdiff_reg;
        s3_gk95_reg  <= s2_gk95_reg;
        s3_bdiff_reg <= s2_bdiff_reg;
        s3_early_reg <= s2_early_reg;

        s4_t10_reg   <= s4_t10_next;
        s4_t15_reg   <= s4_t15_next;
        s4_vr_reg    <= s4_vr_next;
        s4_vg_reg    <= s4_vg_next;
        s4_vb_reg    <= s4_vb_next;
        s4_nup_reg   <= s3_nup_reg;
        s4_nd_reg    <= s4_nd_next;
        s4_rdiff_reg <= s3_rdiff_reg;
        s4_gk95_reg  <= s3_gk95_reg;
        s4_bdiff_reg <= s3_bdiff_reg;
        s4_early_reg <= s3_early_reg;

        out_px_reg   <= out_px_next;
    end

    assign ctrl_out = out_ctrl_reg;
    assign px_out   = out_px_reg;

    // every pixel taken comes out through stages s1 to s4 and the output register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_in.valid |-> ##5 ctrl_out.valid)
        else $error("pixel lost in grading pipeline");

    // no result without a pixel taken at the input for it
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_out.valid |-> $past(ctrl_in.valid, 5))
        else $error("result without a matching pixel");

    // pass-through presets return the pixel unchanged
    a_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_out.valid && (ctrl_out.mode == MODE_IDENTITY ||
                            ctrl_out.mode == MODE_SPARE6 ||
                            ctrl_out.mode == MODE_SPARE7))
        |-> (px_out.red_out == $past(px_in.red_in, 5) &&
             px_out.green_out == $past(px_in.green_in, 5) &&
             px_out.blue_out == $past(px_in.blue_in, 5)))
        else $error("pass-through preset altered the pixel");

    // noir is grey on all channels
    a_noir_grey: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_out.valid && ctrl_out.mode == MODE_NOIR)
        |-> (px_out.red_out == px_out.green_out && px_out.green_out == px_out.blue_out))
        else $error("noir result not grey");

    // sepia keeps red over green over blue
    a_vintage_order: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_out.valid && ctrl_out.mode == MODE_VINTAGE)
        |-> (px_out.red_out >= px_out.green_out && px_out.green_out >= px_out.blue_out))
        else $error("vintage channel order broken");

endmodule

[sv/color_grade_pixel_presets.sv]
// color_grade_pixel_presets: top level of the preset color grading block
// depends on cgpp_pkg and cgpp_grade_pipe
//
// usage:
//   pixel channel: drive pixel_in and raise start; a transfer happens at each
//   rising edge with start high and busy low. busy is high only for the first
//   cycle after reset, so a new pixel may be given every clock.
//   result channel: done is high for exactly one cycle with the graded pixel
//   on pixel_out. the receiver cannot hold results off and none are dropped.
//   configuration: cfg_data carries the 3-bit preset (identity, warm, cool,
//   cinematic, vintage, noir; codes 6 and 7 pass through). it is written at
//   an edge with cfg_valid and cfg_ready high. the preset travels with each
//   pixel, so a write affects only pixels transferred after it.
//   pipeline: done rises once the pixel has passed the input register, three
//   arithmetic stages and the output register. throughput: one pixel per clock.
//   reset: the preset returns to identity and the pipeline empties.
module color_grade_pixel_presets
    import cgpp_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 14
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  pixel_in_t  pixel_in,
    output logic       done,
    output pixel_out_t pixel_out,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_data
);

    logic        busy_reg;
    logic [2:0]  mode_reg, mode_next;
    stage_ctrl_t ctrl_in;
    stage_ctrl_t ctrl_out;

    // preset register write
    always_comb
    begin
        mode_next = mode_reg;
        if (cfg_valid && cfg_ready)
            mode_next = cfg_data;
    end

    // busy only while coming out of reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            mode_reg <= MODE_IDENTITY;
        end
        else
        begin
            busy_reg <= 1'b0;
            mode_reg <= mode_next;
        end
    end

    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg;

    // pixel transfer tags the pipeline with the current preset
    assign ctrl_in.valid = start && !busy_reg;
    assign ctrl_in.mode  = mode_reg;

    cgpp_grade_pipe #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_grade_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (ctrl_in),
        .px_in    (pixel_in),
        .ctrl_out (ctrl_out),
        .px_out   (pixel_out)
    );

    assign done = ctrl_out.valid;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for the color_grade_pixel_presets block
// depends on cgpp_pkg and the block's rtl; a fixed-point grading model predicts every pixel

module tb_top;
    import cgpp_pkg::*;

    localparam int FRAC          = 14;
    localparam int RANDOM_PIXELS = 576;

    // one pixel per preset aimed at that preset's corner cases
    localparam logic [23:0] FOCUS_PX [8] = '{
        24'h5aa53c,   // identity: alternating bit patterns
        24'hdef4c8,   // warm: red and green saturate
        24'hc864d6,   // cool: blue saturates
        24'h4c4c4c,   // cinematic: grey just under the dark-lift threshold
        24'hff0080,   // vintage: strong red, no green
        24'h808080,   // noir: mid grey
        24'h010203,   // unused code passes through
        24'haa55ff    // unused code passes through
    };

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       start     = 1'b0;
    logic       busy;
    pixel_in_t  pixel_in  = '0;
    logic       done;
    pixel_out_t pixel_out;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_data  = '0;

    pixel_in_t  pixel_backlog[$];
    pixel_out_t graded_q[$];
    pixel_out_t want_px;
    logic [2:0] active_mode   = MODE_IDENTITY;
    bit         gaps_on       = 1'b0;
    int         gap_left      = 0;
    int         pixels_queued = 0;
    int         pixels_graded = 0;
    int         error_cnt     = 0;

    color_grade_pixel_presets DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel_in  (pixel_in),
        .done      (done),
        .pixel_out (pixel_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // coefficient rounded to FRAC fraction bits, ties up
    function automatic logic [63:0] coef(input int unsigned num, input int unsigned den);
        return ((64'(num) << FRAC) + 64'(den / 2)) / 64'(den);
    endfunction

    // offset on the 0..255 scale
    function automatic logic [63:0] offs(input int unsigned num, input int unsigned den);
        return 64'd255 * coef(num, den);
    endfunction

    function automatic logic [63:0] scale(input logic [63:0] a, input logic [63:0] k);
        return (a * k) >> FRAC;
    endfunction

    function automatic logic [63:0] clip_one(input logic [63:0] v);
        logic [63:0] one;
        one = 64'd255 << FRAC;
        return (v > one) ? one : v;
    endfunction

    function automatic logic [7:0] to_channel(input logic [63:0] v);
        logic [63:0] whole;
        whole = v >> FRAC;
        return (whole > 64'd255) ? 8'd255 : whole[7:0];
    endfunction

    // bt.601 luma in fixed point
    function automatic logic [63:0] luma(input logic [63:0] r, input logic [63:0] g,
                                         input logic [63:0] b);
        return r * coef(299, 1000) + g * coef(587, 1000) + b * coef(114, 1000);
    endfunction

    // expected graded pixel for one preset
    function automatic pixel_out_t grade_pixel(input logic [2:0] mode, input pixel_in_t px);
        logic [63:0] r, g, b, ro, go, bo, lum, half, dev;
        pixel_out_t  res;
        r  = 64'(px.red_in);
        g  = 64'(px.green_in);
        b  = 64'(px.blue_in);
        ro = r << FRAC;
        go = g << FRAC;
        bo = b << FRAC;
        case (mode)
            MODE_WARM:
            begin
                ro = clip_one(r * coef(115, 100) + offs(5, 100));
                go = clip_one(g * coef(105, 100));
                bo = b * coef(85, 100);
            end
            MODE_COOL:
            begin
                ro = r * coef(85, 100);
                go = clip_one(g * coef(105, 100));
                bo = clip_one(b * coef(120, 100) + offs(5, 100));
            end
            MODE_CINEMATIC:
            begin
                lum = luma(r, g, b);
                if (lum < offs(30, 100))
                    lum = scale(lum, coef(80, 100)) + offs(5, 100);
                ro = clip_one(r * coef(110, 100) + scale(lum, coef(10, 100))
                              - r * coef(10, 100));
                go = clip_one(g * coef(95, 100));
                bo = clip_one(b * coef(105, 100) + scale(lum, coef(15, 100))
                              - b * coef(15, 100));
            end
            MODE_VINTAGE:
            begin
                lum = luma(r, g, b);
                ro  = scale(clip_one(scale(lum, coef(120, 100))), coef(85, 100))
                      + offs(15, 100);
                go  = scale(clip_one(lum), coef(85, 100)) + offs(15, 100);
                bo  = scale(clip_one(scale(lum, coef(80, 100))), coef(85, 100))
                      + offs(15, 100);
            end
            MODE_NOIR:
            begin
                lum  = luma(r, g, b);
                half = offs(50, 100);
                if (lum >= half)
                    ro = clip_one(half + scale(lum - half, coef(150, 100)));
                else
                begin
                    // deviation below mid grey, clamped at black
                    dev = scale(half - lum, coef(150, 100));
                    ro  = (dev >= half) ? 64'd0 : half - dev;
                end
                go = ro;
                bo = ro;
            end
            default:
            begin
            end
        endcase
        res.red_out   = to_channel(ro);
        res.green_out = to_channel(go);
        res.blue_out  = to_channel(bo);
        return res;
    endfunction

    // random pixel: mostly uniform, plus saturating, dark and threshold greys
    function automatic pixel_in_t random_pixel();
        pixel_in_t  px;
        logic [7:0] grey;
        int         pick;
        pick = $urandom_range(0, 9);
        px   = pixel_in_t'($urandom);
        if (pick == 6)
        begin
            px.red_in   = $urandom_range(0, 1) ? 8'hff : 8'h00;
            px.green_in = $urandom_range(0, 1) ? 8'hff : 8'h00;
            px.blue_in  = $urandom_range(0, 1) ? 8'hff : 8'h00;
        end
        else if (pick == 7)
        begin
            case ($urandom_range(0, 3))
                0:       grey = 8'($urandom_range(36, 48));
                1:       grey = 8'($urandom_range(70, 84));
                2:       grey = 8'($urandom_range(120, 136));
                default: grey = 8'($urandom_range(206, 218));
            endcase
            px = '{grey, grey, grey};
        end
        else if (pick == 8)
            px = '{8'($urandom_range(200, 255)), 8'($urandom_range(200, 255)),
                   8'($urandom_range(200, 255))};
        else if (pick == 9)
            px = '{8'($urandom_range(0, 20)), 8'($urandom_range(0, 20)),
                   8'($urandom_range(0, 20))};
        return px;
    endfunction

    task automatic report_error(input string what, input int got, input int want);
        $display("ERROR at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        error_cnt++;
    endtask

    task automatic queue_pixel(input pixel_in_t px);
        pixel_backlog.push_back(px);
        pixels_queued++;
    endtask

    // every queued pixel has come back graded
    task automatic wait_idle();
        while (pixels_graded != pixels_queued)
            @(posedge clk);
    endtask

    // preset write on the configuration channel
    task automatic write_preset(input logic [2:0] mode);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        active_mode = mode;
    endtask

    // pixel driver: one transfer per start/!busy edge, random gaps between pixels when gaps_on is set
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            pixel_in <= '0;
            gap_left = 0;
        end
        else
        begin
            if (start && !busy)
                graded_q.push_back(grade_pixel(active_mode, pixel_in));
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pixel_backlog.size() > 0)
                begin
                    pixel_in <= pixel_backlog.pop_front();
                    start    <= 1'b1;
                    gap_left = gaps_on ? $urandom_range(0, 6) : 0;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // result monitor: compare each strobed pixel with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (graded_q.size() == 0)
                report_error("result with no pixel outstanding, value", int'(pixel_out), 0);
            else
            begin
                want_px = graded_q.pop_front();
                if (pixel_out.red_out !== want_px.red_out)
                    report_error("red_out", pixel_out.red_out, want_px.red_out);
                if (pixel_out.green_out !== want_px.green_out)
                    report_error("green_out", pixel_out.green_out, want_px.green_out);
                if (pixel_out.blue_out !== want_px.blue_out)
                    report_error("blue_out", pixel_out.blue_out, want_px.blue_out);
                pixels_graded++;
            end
        end
    end

    // stimulus: directed pixels per preset, then random bursts under random presets
    initial
    begin
        int         remaining;
        int         burst;
        logic [2:0] mode;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int m = 0; m < 8; m++)
        begin
            write_preset(3'(m));
            gaps_on = $urandom_range(0, 1);
            queue_pixel('0);
            queue_pixel('1);
            queue_pixel(pixel_in_t'(FOCUS_PX[m]));
            wait_idle();
        end

        remaining = RANDOM_PIXELS;
        while (remaining > 0)
        begin
            mode = 3'($urandom_range(0, 7));
            write_preset(mode);
            gaps_on = $urandom_range(0, 2) != 0;
            burst   = $urandom_range(20, 60);
            if (burst > remaining)
                burst = remaining;
            repeat (burst)
                queue_pixel(random_pixel());
            remaining -= burst;
            wait_idle();
        end

        // drain window past the pipeline latency
        repeat (10) @(posedge clk);
        if (error_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
